[hw/rtl/csp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped span pixel writer package
// Shared types, register indexes, field widths and the colour formatter.
// ----------------------------------------------------------------------------
package csp_pkg;

   localparam int RES_W    = 13;
   localparam int COORD_W  = 13;
   localparam int LEN_W    = 6;
   localparam int MASK_W   = 32;
   localparam int COLOR_W  = 32;
   localparam int OFFSET_W = 26;
   localparam int FMT_W    = 2;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_X_RES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_RES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIX_FMT = 2'd2;

   // Pixel formats; the code doubles as the write size.
   localparam logic [FMT_W-1:0] FMT_8BPP  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_16BPP = 2'd1;
   localparam logic [FMT_W-1:0] FMT_32BPP = 2'd2;

   // Span modes.
   localparam logic MODE_FILL  = 1'b0;
   localparam logic MODE_GLYPH = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [RES_W-1:0] X_RES_RESET   = 13'd800;
   localparam logic [RES_W-1:0] Y_RES_RESET   = 13'd480;
   localparam logic [FMT_W-1:0] PIX_FMT_RESET = FMT_16BPP;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN
   } csp_state_type;

   typedef struct packed {
      logic load;   // capture the request word
      logic prep;   // build the visibility mask and the row base
      logic step;   // advance one span position
   } csp_cmd_type;

   typedef struct packed {
      logic final_pos;  // no visible pixel beyond the current position
   } csp_status_type;

   function automatic logic [COLOR_W-1:0] format_colour(input logic [COLOR_W-1:0] c,
                                                         input logic [FMT_W-1:0] fmt);
      logic [COLOR_W-1:0] v;
      begin
         case (fmt)
            FMT_8BPP: begin
               v = {24'd0, c[7:0]};
            end
            FMT_16BPP: begin
               v = {16'd0, c[23:19], c[15:10], c[7:3]};
            end
            default: begin
               v = c;
            end
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

[hw/rtl/csp_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Span writer controller
// Sequences accept, preparation and the per-position run of one span.
// ----------------------------------------------------------------------------
module csp_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire csp_pkg::csp_status_type status,
   output csp_pkg::csp_cmd_type         cmd,
   output logic                         busy
);
   import csp_pkg::*;

   csp_state_type state_ff;
   csp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.final_pos) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

[hw/rtl/csp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Span writer datapath
// Configuration registers, span capture, clipping mask, offsets and outputs.
// ----------------------------------------------------------------------------
module csp_datapath #(
   parameter int SPAN_PIXELS = 32,
   parameter int MAX_RES     = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire csp_pkg::csp_cmd_type                 cmd,
   output csp_pkg::csp_status_type                   status,
   input  wire logic                                 req_mode,
   input  wire logic signed [csp_pkg::COORD_W-1:0]   req_x_start,
   input  wire logic signed [csp_pkg::COORD_W-1:0]   req_row_y,
   input  wire logic [csp_pkg::LEN_W-1:0]            req_span_length,
   input  wire logic [csp_pkg::MASK_W-1:0]           req_row_mask,
   input  wire logic [csp_pkg::COLOR_W-1:0]          req_color,
   input  wire logic                                 csr_write_enable,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [csp_pkg::RES_W-1:0]            csr_write_data,
   output logic                                      rsp_valid,
   output logic [csp_pkg::OFFSET_W-1:0]              rsp_byte_offset,
   output logic [csp_pkg::COLOR_W-1:0]               rsp_pixel_value,
   output logic [csp_pkg::FMT_W-1:0]                 rsp_write_size,
   output logic                                      rsp_last
);
   import csp_pkg::*;

   localparam logic [RES_W:0] MAX_RES_W = (RES_W+1)'(MAX_RES);

   // Configuration registers.
   logic [RES_W-1:0] x_res_ff;
   logic [RES_W-1:0] y_res_ff;
   logic [FMT_W-1:0] pix_fmt_ff;

   // Captured request word.
   logic                      mode_ff;
   logic signed [COORD_W-1:0] x_start_ff;
   logic signed [COORD_W-1:0] row_y_ff;
   logic [LEN_W-1:0]          span_length_ff;
   logic [MASK_W-1:0]         row_mask_ff;
   logic [COLOR_W-1:0]        color_ff;

   // Run state. The x counter only matters at visible positions, where it
   // always lies inside the screen, so it may wrap elsewhere.
   logic [SPAN_PIXELS-1:0]    vis_ff;
   logic [SPAN_PIXELS-1:0]    vis_in;
   logic [SPAN_PIXELS-1:0]    vis_rest;
   logic [OFFSET_W-1:0]       base_ff;
   logic [OFFSET_W-1:0]       base_in;
   logic [COORD_W-1:0]        x_cur_ff;

   // Output registers.
   logic                  rsp_valid_ff;
   logic [OFFSET_W-1:0]   rsp_byte_offset_ff;
   logic [OFFSET_W-1:0]   rsp_byte_offset_in;
   logic [COLOR_W-1:0]    rsp_pixel_value_ff;
   logic [FMT_W-1:0]      rsp_write_size_ff;
   logic                  rsp_last_ff;

   logic [RES_W-1:0] x_res_c;
   logic [RES_W-1:0] y_res_c;
   logic             row_ok;
   logic [OFFSET_W-1:0] linear;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_res_ff   <= X_RES_RESET;
         y_res_ff   <= Y_RES_RESET;
         pix_fmt_ff <= PIX_FMT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_X_RES: begin
               x_res_ff <= csr_write_data;
            end
            REG_Y_RES: begin
               y_res_ff <= csr_write_data;
            end
            REG_PIX_FMT: begin
               pix_fmt_ff <= csr_write_data[FMT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Resolutions above the supported maximum behave as the maximum.
   assign x_res_c = ({1'b0, x_res_ff} > MAX_RES_W) ? MAX_RES_W[RES_W-1:0] : x_res_ff;
   assign y_res_c = ({1'b0, y_res_ff} > MAX_RES_W) ? MAX_RES_W[RES_W-1:0] : y_res_ff;

   assign row_ok = (pix_fmt_ff <= FMT_32BPP) && !row_y_ff[COORD_W-1]
                   && ($unsigned(row_y_ff) < y_res_c);

   always_comb begin
      logic signed [COORD_W:0] xs;
      logic                    on;
      vis_in = '0;
      for (int p = 0; p < SPAN_PIXELS; p++) begin
         xs = {x_start_ff[COORD_W-1], x_start_ff} + (COORD_W+1)'(p);
         on = (mode_ff == MODE_FILL) || (((row_mask_ff >> p) & 32'd1) != 32'd0);
         vis_in[p] = row_ok && on && ((LEN_W+1)'(p) < {1'b0, span_length_ff})
                     && !xs[COORD_W] && (xs[COORD_W-1:0] < x_res_c);
      end
   end

   assign base_in  = {{(OFFSET_W-RES_W){1'b0}}, $unsigned(row_y_ff)}
                     * {{(OFFSET_W-RES_W){1'b0}}, x_res_c};
   assign vis_rest = vis_ff >> 1;
   assign status.final_pos = (vis_rest == '0);

   assign linear = base_ff + {{(OFFSET_W-COORD_W){1'b0}}, x_cur_ff};
   assign rsp_byte_offset_in = linear << pix_fmt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff        <= req_mode;
         x_start_ff     <= req_x_start;
         row_y_ff       <= req_row_y;
         span_length_ff <= req_span_length;
         row_mask_ff    <= req_row_mask;
         color_ff       <= req_color;
      end
      if (cmd.prep) begin
         base_ff  <= base_in;
         x_cur_ff <= $unsigned(x_start_ff);
      end else if (cmd.step) begin
         x_cur_ff <= x_cur_ff + COORD_W'(1);
      end
      if (cmd.step && vis_ff[0]) begin
         rsp_byte_offset_ff <= rsp_byte_offset_in;
         rsp_pixel_value_ff <= format_colour(color_ff, pix_fmt_ff);
         rsp_write_size_ff  <= pix_fmt_ff;
         rsp_last_ff        <= status.final_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.prep) begin
            vis_ff <= vis_in;
         end else if (cmd.step) begin
            vis_ff <= vis_rest;
         end
         rsp_valid_ff <= cmd.step && vis_ff[0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_offset = rsp_byte_offset_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;
   assign rsp_write_size  = rsp_write_size_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

[hw/rtl/clipped_span_pixel_writer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped span pixel writer
// Turns one horizontal span into clipped, formatted framebuffer writes.
// ----------------------------------------------------------------------------
// A span word is taken at a clock edge where start is high and busy is low.
// The block then builds, in its preparation state, a visibility mask for
// every span position (clipping against the screen, the glyph mask and the
// length, and clearing it for an invalid pixel format) and the row base
// y*x_resolution, and afterwards walks the span one position a cycle,
// stopping after the last visible pixel. Busy stays high through the
// preparation and the walk; a span with nothing visible gives no word. Each
// write word appears on the rsp_ ports for a single cycle with rsp_valid high,
// in the cycle after its position is visited, and must be taken then: there
// is no back-pressure. The last word of a span carries rsp_last, and it shows
// in the first cycle in which busy is low again. Configuration writes are
// meant for idle periods.
// ----------------------------------------------------------------------------
module clipped_span_pixel_writer #(
   parameter int SPAN_PIXELS = 32,
   parameter int MAX_RES     = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_mode,
   input  wire logic signed [csp_pkg::COORD_W-1:0]   req_x_start,
   input  wire logic signed [csp_pkg::COORD_W-1:0]   req_row_y,
   input  wire logic [csp_pkg::LEN_W-1:0]            req_span_length,
   input  wire logic [csp_pkg::MASK_W-1:0]           req_row_mask,
   input  wire logic [csp_pkg::COLOR_W-1:0]          req_color,
   output logic                                      rsp_valid,
   output logic [csp_pkg::OFFSET_W-1:0]              rsp_byte_offset,
   output logic [csp_pkg::COLOR_W-1:0]               rsp_pixel_value,
   output logic [csp_pkg::FMT_W-1:0]                 rsp_write_size,
   output logic                                      rsp_last,
   input  wire logic                                 csr_write_enable,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [csp_pkg::RES_W-1:0]            csr_write_data
);
   import csp_pkg::*;

   csp_cmd_type    cmd;
   csp_status_type status;

   // The controller only sequences; all arithmetic sits in the datapath.
   csp_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   csp_datapath #(
      .SPAN_PIXELS (SPAN_PIXELS),
      .MAX_RES     (MAX_RES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_x_start      (req_x_start),
      .req_row_y        (req_row_y),
      .req_span_length  (req_span_length),
      .req_row_mask     (req_row_mask),
      .req_color        (req_color),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_write_size   (rsp_write_size),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

[hw/rtl/csp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Span writer port checker
// Watches the top-level ports for sequencing and alignment slips.
// ----------------------------------------------------------------------------
module csp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [csp_pkg::OFFSET_W-1:0]      rsp_byte_offset,
   input wire logic [csp_pkg::FMT_W-1:0]         rsp_write_size,
   input wire logic                              rsp_last
);
   import csp_pkg::*;

   // An accepted span keeps the block busy in the following cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("span accepted but block not busy");

   // A word that is not the last of its span implies the walk continues.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final word while idle");

   // The last word arrives as the block returns to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final word while still busy");

   // Writes are naturally aligned to their size.
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_size == FMT_8BPP)
                 || (rsp_write_size == FMT_16BPP && rsp_byte_offset[0] == 1'b0)
                 || (rsp_write_size == FMT_32BPP && rsp_byte_offset[1:0] == 2'b00))
      else $error("misaligned or invalid write");

endmodule

bind clipped_span_pixel_writer csp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_write_size  (rsp_write_size),
   .rsp_last        (rsp_last)
);
`default_nettype wire
